### src/gkh_pkg.sv
// ----------------------------------------------------------------------------
// gkh_pkg
// Types and constants shared by the Gaussian kernel Hessian block.
// ----------------------------------------------------------------------------
package gkh_pkg;

  // Configuration register indexes
  localparam logic [3:0] CFG_BANDWIDTH = 4'd0;
  localparam logic [3:0] CFG_DIMENSION = 4'd1;

  // ln 2 in Q0.32, number of series terms and the exponent cut-off
  localparam logic [31:0] LN2_Q32   = 32'hB17217F8;
  localparam logic [3:0]  EXP_TERMS = 4'd10;
  localparam int          K_CUTOFF_SH = 5;   // cut-off is 32 * sigma

  // floor(2^48 / LN2_Q32): the range reduction estimates n as (x * this) >> 32,
  // which is never above the true quotient and at most one below it.
  localparam logic [31:0] LN2_RECIP = 32'd94548;

  // Numerator bit counts for the divisions of the datapath
  localparam logic [6:0] NB_X    = 7'd53;
  localparam logic [6:0] NB_EXP  = 7'd32;
  localparam logic [6:0] NB_DIAG = 7'd34;
  localparam logic [6:0] NB_U    = 7'd64;
  localparam logic [6:0] NB_OFF  = 7'd41;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_MUL,
    S_SQ_ADD,
    S_K_CHK,
    S_X_DIV,
    S_N_MUL,
    S_N_EST,
    S_N_FIX,
    S_EXP_MUL,
    S_EXP_ST,
    S_EXP_DIV,
    S_K_SET,
    S_DG_DIV,
    S_RD_I,
    S_RD_J,
    S_M_MUL,
    S_M_ST,
    S_U_DIV,
    S_V_MUL1,
    S_V_MUL2,
    S_V_SUM,
    S_OFF_ST,
    S_OFF_DIV,
    S_EMIT
  } gkh_state_t;

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
    logic [6:0]  nbits;
  } gkh_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } gkh_div_rsp_t;

endpackage

### src/gkh_ifs.sv
// ----------------------------------------------------------------------------
// gkh interfaces
// Valid/ready channels for coordinate pairs, Hessian entries and config writes.
// ----------------------------------------------------------------------------
interface gkh_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_a_coord;
  logic signed [31:0] point_b_coord;
  modport source (output valid, output point_a_coord, output point_b_coord, input ready);
  modport sink   (input valid, input point_a_coord, input point_b_coord, output ready);
endinterface

interface gkh_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] entry_value;
  logic [2:0]         entry_row;
  logic [2:0]         entry_col;
  logic               entry_last;
  modport source (output valid, output entry_value, output entry_row, output entry_col,
                  output entry_last, input ready);
  modport sink   (input valid, input entry_value, input entry_row, input entry_col,
                  input entry_last, output ready);
endinterface

interface gkh_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/gkh_div.sv
// ----------------------------------------------------------------------------
// gkh_div
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
// ----------------------------------------------------------------------------
module gkh_div
  import gkh_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  gkh_div_req_t req,
  output gkh_div_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic [6:0]  cnt_r;
  logic [63:0] num_r;
  logic [63:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;

  logic [32:0] rem_w;
  logic        ge;

  // One restoring step on the next numerator bit
  always_comb begin
    rem_w = {rem_r, num_r[63]};
    ge    = (rem_w >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      num_r <= {num_r[62:0], 1'b0};
      quo_r <= {quo_r[62:0], ge};
      rem_r <= ge ? 32'(rem_w - {1'b0, den_r}) : rem_w[31:0];
    end else if (req.start) begin
      cnt_r <= req.nbits;
      num_r <= req.num << (7'd64 - req.nbits);
      quo_r <= '0;
      rem_r <= '0;
      den_r <= req.den;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

### src/gaussian_kernel_hessian_top.sv
// ----------------------------------------------------------------------------
// gaussian_kernel_hessian_top
// Gaussian RBF kernel Hessian from two streamed points, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Each coordinate pair passes a memory write, a square and an accumulate step.
// The last pair of a point then computes k and the diagonal term (53-bit division,
// ln 2 range reduction, ten 32-bit and one 34-bit division), skipped at the cut-off.
// Each of the D*D entries then uses a 64- and a 41-bit division, plus any output stall;
// the multiply by k is skipped when k is exactly one, and both divisions when k is zero.
// Synchronous active-low reset clears count, accumulator, sigma = 1.0, D = 1, not the memory.
module gaussian_kernel_hessian_top
  import gkh_pkg::*;
#(
  parameter int MAX_DIM = 8
) (
  input  logic clk,
  input  logic rst_n,
  gkh_in_if.sink    in_stream,
  gkh_out_if.source out_stream,
  gkh_cfg_if.sink   cfg_port
);

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [3:0] DMAX = 4'(MAX_DIM);

  gkh_state_t state_r, state_nxt;

  // Configuration and point state
  logic [31:0] bandwidth_r;
  logic [3:0]  dimension_r;
  logic [3:0]  count_r;
  logic [63:0] acc_r;
  logic [3:0]  dim_r;
  logic [31:0] ad_r;
  logic        complete_r;

  // Exponential and entry datapath
  logic [5:0]  n_r;
  logic [31:0] r_r;
  logic [32:0] p_r;
  logic [3:0]  t_r;
  logic [32:0] k_r;
  logic [33:0] diag_r;
  logic [2:0]  i_r, j_r;
  logic signed [32:0] di_r, dj_r;
  logic [63:0] u_r;
  logic [31:0] tmp_r, v_r;
  logic [31:0] val_r;
  logic [63:0] prod_r;

  // Output register
  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic [2:0]  out_row_r, out_col_r;
  logic        out_last_r;

  // Difference memory
  logic signed [32:0] mem [MAX_DIM];
  logic signed [32:0] rd_data_r;
  logic [AW-1:0]      rd_addr;

  gkh_div_req_t div_req;
  gkh_div_rsp_t div_rsp;

  gkh_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // Effective settings
  logic [31:0] s_eff;
  logic [3:0]  dim_eff;
  always_comb begin
    s_eff   = (bandwidth_r == 32'd0) ? 32'd1 : bandwidth_r;
    dim_eff = (dimension_r == 4'd0) ? 4'd1 : ((dimension_r > DMAX) ? DMAX : dimension_r);
  end

  // Incoming pair: difference, magnitude and memory slot
  logic               in_xfer;
  logic signed [32:0] d_in;
  logic [32:0]        ad_in;
  logic [3:0]         slot;
  assign in_xfer = in_stream.valid && in_stream.ready;
  always_comb begin
    d_in  = 33'(in_stream.point_a_coord) - 33'(in_stream.point_b_coord);
    ad_in = d_in[32] ? 33'(-d_in) : d_in;
    slot  = (count_r < DMAX) ? count_r : (DMAX - 4'd1);
  end

  // Configuration writes
  assign cfg_port.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bandwidth_r <= 32'd65536;
      dimension_r <= 4'd1;
    end else if (cfg_port.valid) begin
      unique case (cfg_port.index)
        CFG_BANDWIDTH: bandwidth_r <= cfg_port.data;
        CFG_DIMENSION: dimension_r <= cfg_port.data[3:0];
        default: ;
      endcase
    end
  end

  // Memory: write on an input transfer, registered read
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mem[slot[AW-1:0]] <= d_in;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Shared 32 by 32 multiplier, registered
  logic [31:0] mul_a, mul_b;
  logic [31:0] mag_di, mag_rd;
  always_comb begin
    logic [32:0] t1, t2;
    t1     = di_r[32] ? 33'(-di_r) : di_r;
    t2     = rd_data_r[32] ? 33'(-rd_data_r) : rd_data_r;
    mag_di = t1[31:0];
    mag_rd = t2[31:0];
    mul_a  = ad_r;
    mul_b  = ad_r;
    case (state_r)
      S_N_MUL:   begin mul_a = {11'd0, div_rsp.quo[20:0]}; mul_b = LN2_RECIP; end
      S_N_EST:   begin mul_a = {26'd0, prod_r[37:32]};     mul_b = LN2_Q32;   end
      S_EXP_MUL: begin mul_a = r_r;        mul_b = p_r[31:0]; end
      S_M_MUL:   begin mul_a = mag_di;     mul_b = mag_rd;    end
      S_V_MUL1:  begin mul_a = u_r[31:0];  mul_b = k_r[31:0]; end
      S_V_MUL2:  begin mul_a = u_r[63:32]; mul_b = k_r[31:0]; end
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Range reduction remainder: x << 16 less the estimated multiple of ln 2.
  // The divider holds x while it is idle, and the estimate is short by at most one.
  logic [36:0] r_full;
  logic        r_over;
  always_comb begin
    r_full = {div_rsp.quo[20:0], 16'd0} - prod_r[36:0];
    r_over = (r_full >= {5'd0, LN2_Q32});
  end

  // Entry value from the registered differences and the offset quotient
  logic [31:0] ent_val;
  always_comb begin
    logic signed [43:0] val;
    logic               same, nz;
    val  = (i_r == j_r) ? 44'(diag_r) : 44'sd0;
    same = (!di_r[32] && di_r != 0 && !dj_r[32] && dj_r != 0) || (di_r[32] && dj_r[32]);
    nz   = (di_r != 0) && (dj_r != 0);
    if (same) begin
      val = val - 44'(div_rsp.quo[40:0]);
    end else if (nz) begin
      val = val + 44'(div_rsp.quo[40:0]);
    end
    if (val > 44'sd2147483647) begin
      ent_val = 32'h7FFF_FFFF;
    end else if (val < -44'sd2147483648) begin
      ent_val = 32'h8000_0000;
    end else begin
      ent_val = val[31:0];
    end
  end

  logic out_xfer;
  assign out_xfer = out_stream.valid && out_stream.ready;

  // Sequencer: next state, divider requests and read address
  always_comb begin
    logic [32:0] k_nxt;
    k_nxt         = p_r >> n_r;
    state_nxt     = state_r;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = s_eff;
    div_req.nbits = NB_X;
    rd_addr       = i_r[AW-1:0];
    unique case (state_r)
      S_IDLE:    if (in_xfer) state_nxt = S_SQ_MUL;
      S_SQ_MUL:  state_nxt = S_SQ_ADD;
      S_SQ_ADD:  state_nxt = complete_r ? S_K_CHK : S_IDLE;
      S_K_CHK: begin
        if (acc_r >= ({32'd0, s_eff} << K_CUTOFF_SH)) begin
          state_nxt = S_RD_I;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = {acc_r[47:0], 16'd0};
          state_nxt     = S_X_DIV;
        end
      end
      S_X_DIV:   if (div_rsp.done) state_nxt = S_N_MUL;
      S_N_MUL:   state_nxt = S_N_EST;
      S_N_EST:   state_nxt = S_N_FIX;
      S_N_FIX:   state_nxt = S_EXP_MUL;
      S_EXP_MUL: state_nxt = S_EXP_ST;
      S_EXP_ST: begin
        div_req.start = 1'b1;
        div_req.num   = {32'd0, (p_r[32] ? r_r : prod_r[63:32])};
        div_req.den   = {28'd0, t_r};
        div_req.nbits = NB_EXP;
        state_nxt     = S_EXP_DIV;
      end
      S_EXP_DIV: if (div_rsp.done) state_nxt = (t_r == 4'd1) ? S_K_SET : S_EXP_MUL;
      S_K_SET: begin
        div_req.start = 1'b1;
        div_req.num   = {30'd0, k_nxt, 1'b0};
        div_req.nbits = NB_DIAG;
        state_nxt     = S_DG_DIV;
      end
      S_DG_DIV:  if (div_rsp.done) state_nxt = S_RD_I;
      S_RD_I:    state_nxt = (k_r == 33'd0) ? S_EMIT : S_RD_J;
      S_RD_J: begin
        rd_addr   = j_r[AW-1:0];
        state_nxt = S_M_MUL;
      end
      S_M_MUL:   state_nxt = S_M_ST;
      S_M_ST: begin
        div_req.start = 1'b1;
        div_req.num   = {prod_r[54:0], 9'd0};
        div_req.nbits = NB_U;
        state_nxt     = S_U_DIV;
      end
      S_U_DIV:   if (div_rsp.done) state_nxt = k_r[32] ? S_OFF_ST : S_V_MUL1;
      S_V_MUL1:  state_nxt = S_V_MUL2;
      S_V_MUL2:  state_nxt = S_V_SUM;
      S_V_SUM:   state_nxt = S_OFF_ST;
      S_OFF_ST: begin
        div_req.start = 1'b1;
        div_req.num   = {23'd0, v_r, 9'd0};
        div_req.nbits = NB_OFF;
        state_nxt     = S_OFF_DIV;
      end
      S_OFF_DIV: if (div_rsp.done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (!out_valid_r || out_stream.ready) begin
          if ({1'b0, i_r} == dim_r - 4'd1 && {1'b0, j_r} == dim_r - 4'd1) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_RD_I;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stream.ready = (state_r == S_IDLE);

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= 4'd0;
      acc_r       <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        count_r <= ({1'b0, slot} + 5'd1 >= {1'b0, dim_eff}) ? 4'd0 : slot + 4'd1;
      end
      if (state_r == S_SQ_ADD) begin
        acc_r <= acc_r + {16'd0, prod_r[63:16]};
      end else if (state_r == S_K_CHK) begin
        acc_r <= 64'd0;
      end
      if (state_r == S_EMIT && (!out_valid_r || out_stream.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ad_r       <= ad_in[31:0];
      complete_r <= ({1'b0, slot} + 5'd1 >= {1'b0, dim_eff});
      dim_r      <= dim_eff;
    end
    case (state_r)
      S_K_CHK: begin
        k_r    <= 33'd0;
        diag_r <= 34'd0;
        i_r    <= 3'd0;
        j_r    <= 3'd0;
      end
      S_N_EST:   n_r <= prod_r[37:32];
      S_N_FIX: begin
        if (r_over) begin
          n_r <= n_r + 6'd1;
          r_r <= 32'(r_full - {5'd0, LN2_Q32});
        end else begin
          r_r <= r_full[31:0];
        end
        p_r <= 33'h1_0000_0000;
        t_r <= EXP_TERMS;
      end
      S_EXP_DIV: begin
        if (div_rsp.done) begin
          p_r <= 33'h1_0000_0000 - div_rsp.quo[32:0];
          t_r <= t_r - 4'd1;
        end
      end
      S_K_SET:   k_r <= p_r >> n_r;
      S_DG_DIV:  if (div_rsp.done) diag_r <= div_rsp.quo[33:0];
      S_RD_I:    val_r <= 32'd0;
      S_RD_J:    di_r <= rd_data_r;
      S_M_MUL:   dj_r <= rd_data_r;
      S_U_DIV: begin
        if (div_rsp.done) begin
          u_r <= div_rsp.quo;
          v_r <= div_rsp.quo[31:0];
        end
      end
      S_V_MUL2:  tmp_r <= prod_r[63:32];
      S_V_SUM:   v_r <= tmp_r + prod_r[31:0];
      S_OFF_DIV: if (div_rsp.done) val_r <= ent_val;
      S_EMIT: begin
        if (!out_valid_r || out_stream.ready) begin
          out_value_r <= val_r;
          out_row_r   <= i_r;
          out_col_r   <= j_r;
          out_last_r  <= ({1'b0, i_r} == dim_r - 4'd1) && ({1'b0, j_r} == dim_r - 4'd1);
          if ({1'b0, i_r} == dim_r - 4'd1) begin
            i_r <= 3'd0;
            j_r <= j_r + 3'd1;
          end else begin
            i_r <= i_r + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_stream.valid       = out_valid_r;
  assign out_stream.entry_value = out_value_r;
  assign out_stream.entry_row   = out_row_r;
  assign out_stream.entry_col   = out_col_r;
  assign out_stream.entry_last  = out_last_r;

endmodule
